// ----- src/i2cme_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, command codes, sequencer phases and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cme_pkg;

  // Command codes carried by an input item.
  typedef enum logic [2:0] {
    CmdTick  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdWrite = 3'd3,
    CmdRead  = 3'd4,
    CmdAddr  = 3'd5
  } cmd_t;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhStWait  = 4'd1,
    PhStSetup = 4'd2,
    PhStHold  = 4'd3,
    PhSpWait  = 4'd4,
    PhSpSetup = 4'd5,
    PhSpFree  = 4'd6,
    PhBitLow  = 4'd7,
    PhBitWait = 4'd8,
    PhBitHigh = 4'd9
  } phase_t;

  // Configuration register indexes.
  localparam logic [0:0] CfgLowIdx  = 1'b0;
  localparam logic [0:0] CfgHighIdx = 1'b1;

  // Bit slot that carries the acknowledge.
  localparam logic [3:0] AckSlot = 4'd8;

  localparam logic [7:0] ByteOnes = 8'hFF;

  // One input item.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [6:0] target_address;
    logic       read_not_write;
    logic       more_follows;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] received_byte;
    logic       ack_level;
    logic       cmd_rejected;
  } result_t;

  // Timing configuration.
  typedef struct packed {
    logic [15:0] low_phase_ticks;
    logic [15:0] high_phase_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/i2cme_in_stage.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine input register
// Holds one accepted item until the sequencer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cme_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire i2cme_pkg::item_t up_item,
  output logic                 dn_valid,
  input  wire logic            dn_take,
  output i2cme_pkg::item_t     dn_item
);

  logic             valid_r;
  i2cme_pkg::item_t item_r;

  // A new transfer is taken when the register is empty or drains this cycle.
  assign up_ready = !valid_r || dn_take;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Payload register, loaded on every accepted transfer.
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= up_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2cme_seq.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer
// Holds the bus state and advances it by one step per item.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cme_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire i2cme_pkg::item_t  item,
  input  wire i2cme_pkg::cfg_t   cfg,
  output i2cme_pkg::result_t     res,
  output i2cme_pkg::phase_t      phase
);

  i2cme_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]        op_kind_r, op_kind_nxt;
  logic [15:0]       delay_count_r, delay_count_nxt;
  logic [7:0]        shift_reg_r, shift_reg_nxt;
  logic [3:0]        bit_index_r, bit_index_nxt;
  logic              ack_to_send_r, ack_to_send_nxt;
  logic              ack_seen_r, ack_seen_nxt;
  logic              scl_drive_r, scl_drive_nxt;
  logic              sda_drive_r, sda_drive_nxt;
  logic [7:0]        rx_hold_r, rx_hold_nxt;

  logic              is_cmd;
  logic              idle;
  logic              expired;
  logic [15:0]       delay_dec;
  logic [7:0]        begin_val;
  logic [3:0]        bit_inc;
  logic              op_is_read;
  logic              rejected;
  logic              done;

  assign phase = phase_r;
  assign idle  = (phase_r == i2cme_pkg::PhIdle);

  // Commands one to five start an operation.
  always_comb begin
    case (item.cmd) inside
      i2cme_pkg::CmdStart, i2cme_pkg::CmdStop, i2cme_pkg::CmdWrite,
      i2cme_pkg::CmdRead, i2cme_pkg::CmdAddr: is_cmd = 1'b1;
      default:                                is_cmd = 1'b0;
    endcase
  end

  // One tick of a timed phase; a count of zero or one runs out at once.
  assign expired   = (delay_count_r <= 16'd1);
  assign delay_dec = expired ? 16'd0 : (delay_count_r - 16'd1);
  assign bit_inc   = bit_index_r + 4'd1;
  assign op_is_read = (op_kind_r == i2cme_pkg::CmdRead);

  // Byte loaded into the shifter when a byte command starts.
  always_comb begin
    case (item.cmd)
      i2cme_pkg::CmdWrite: begin_val = item.data_byte;
      i2cme_pkg::CmdAddr:  begin_val = {item.target_address, item.read_not_write};
      default:             begin_val = i2cme_pkg::ByteOnes;
    endcase
  end

  // Next-state logic of the bus sequencer.
  always_comb begin
    phase_nxt       = phase_r;
    op_kind_nxt     = op_kind_r;
    delay_count_nxt = delay_count_r;
    shift_reg_nxt   = shift_reg_r;
    bit_index_nxt   = bit_index_r;
    ack_to_send_nxt = ack_to_send_r;
    ack_seen_nxt    = ack_seen_r;
    scl_drive_nxt   = scl_drive_r;
    sda_drive_nxt   = sda_drive_r;
    rx_hold_nxt     = rx_hold_r;
    rejected        = 1'b0;
    done            = 1'b0;

    if (is_cmd && idle) begin
      op_kind_nxt = item.cmd;
      unique case (item.cmd) inside
        i2cme_pkg::CmdStart: begin
          scl_drive_nxt = 1'b1;
          sda_drive_nxt = 1'b1;
          phase_nxt     = i2cme_pkg::PhStWait;
        end
        i2cme_pkg::CmdStop: begin
          sda_drive_nxt = 1'b0;
          scl_drive_nxt = 1'b1;
          phase_nxt     = i2cme_pkg::PhSpWait;
        end
        default: begin
          // Byte commands: first data slot starts with SCL low.
          if (item.cmd == i2cme_pkg::CmdRead) begin
            ack_to_send_nxt = !item.more_follows;
          end
          shift_reg_nxt   = begin_val;
          bit_index_nxt   = 4'd0;
          scl_drive_nxt   = 1'b0;
          delay_count_nxt = cfg.low_phase_ticks;
          sda_drive_nxt   = (item.cmd == i2cme_pkg::CmdRead) ? 1'b1 : begin_val[7];
          phase_nxt       = i2cme_pkg::PhBitLow;
        end
      endcase
    end else begin
      rejected = is_cmd;
      unique case (phase_r)
        i2cme_pkg::PhIdle: begin
        end
        i2cme_pkg::PhStWait: begin
          if (item.scl_in) begin
            delay_count_nxt = cfg.low_phase_ticks;
            phase_nxt       = i2cme_pkg::PhStSetup;
          end
        end
        i2cme_pkg::PhStSetup: begin
          delay_count_nxt = delay_dec;
          if (expired) begin
            sda_drive_nxt   = 1'b0;
            delay_count_nxt = cfg.low_phase_ticks;
            phase_nxt       = i2cme_pkg::PhStHold;
          end
        end
        i2cme_pkg::PhStHold: begin
          delay_count_nxt = delay_dec;
          if (expired) begin
            scl_drive_nxt = 1'b0;
            sda_drive_nxt = 1'b1;
            phase_nxt     = i2cme_pkg::PhIdle;
            done          = 1'b1;
          end
        end
        i2cme_pkg::PhSpWait: begin
          if (item.scl_in) begin
            delay_count_nxt = cfg.low_phase_ticks;
            phase_nxt       = i2cme_pkg::PhSpSetup;
          end
        end
        i2cme_pkg::PhSpSetup: begin
          delay_count_nxt = delay_dec;
          if (expired) begin
            sda_drive_nxt   = 1'b1;
            delay_count_nxt = cfg.high_phase_ticks;
            phase_nxt       = i2cme_pkg::PhSpFree;
          end
        end
        i2cme_pkg::PhSpFree: begin
          delay_count_nxt = delay_dec;
          if (expired) begin
            phase_nxt = i2cme_pkg::PhIdle;
            done      = 1'b1;
          end
        end
        i2cme_pkg::PhBitLow: begin
          delay_count_nxt = delay_dec;
          if (expired) begin
            scl_drive_nxt = 1'b1;
            phase_nxt     = i2cme_pkg::PhBitWait;
          end
        end
        i2cme_pkg::PhBitWait: begin
          // The target may stretch the clock; sample SDA once SCL reads high.
          if (item.scl_in) begin
            if (bit_index_r < i2cme_pkg::AckSlot) begin
              shift_reg_nxt = {shift_reg_r[6:0], item.sda_in};
            end else if (!op_is_read) begin
              ack_seen_nxt = item.sda_in;
            end
            delay_count_nxt = cfg.high_phase_ticks;
            phase_nxt       = i2cme_pkg::PhBitHigh;
          end
        end
        i2cme_pkg::PhBitHigh: begin
          delay_count_nxt = delay_dec;
          if (expired) begin
            scl_drive_nxt = 1'b0;
            if (bit_index_r >= i2cme_pkg::AckSlot) begin
              // End of the acknowledge slot closes the byte.
              if (op_is_read) begin
                rx_hold_nxt = shift_reg_r;
              end
              shift_reg_nxt = i2cme_pkg::ByteOnes;
              sda_drive_nxt = 1'b1;
              bit_index_nxt = 4'd0;
              phase_nxt     = i2cme_pkg::PhIdle;
              done          = 1'b1;
            end else begin
              bit_index_nxt   = bit_inc;
              delay_count_nxt = cfg.low_phase_ticks;
              if (bit_inc < i2cme_pkg::AckSlot) begin
                sda_drive_nxt = op_is_read ? 1'b1 : shift_reg_r[7];
              end else begin
                sda_drive_nxt = op_is_read ? ack_to_send_r : 1'b1;
              end
              phase_nxt = i2cme_pkg::PhBitLow;
            end
          end
        end
        default: begin
          phase_nxt = i2cme_pkg::PhIdle;
        end
      endcase
    end
  end

  // Result fields reflect the state after this step.
  always_comb begin
    res.scl_release   = scl_drive_nxt;
    res.sda_release   = sda_drive_nxt;
    res.busy_res      = (phase_nxt != i2cme_pkg::PhIdle);
    res.done_res      = done;
    res.received_byte = rx_hold_nxt;
    res.ack_level     = ack_seen_nxt;
    res.cmd_rejected  = rejected;
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= i2cme_pkg::PhIdle;
      op_kind_r     <= 3'd0;
      delay_count_r <= 16'd0;
      shift_reg_r   <= i2cme_pkg::ByteOnes;
      bit_index_r   <= 4'd0;
      ack_to_send_r <= 1'b0;
      ack_seen_r    <= 1'b1;
      scl_drive_r   <= 1'b1;
      sda_drive_r   <= 1'b1;
      rx_hold_r     <= 8'd0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      op_kind_r     <= op_kind_nxt;
      delay_count_r <= delay_count_nxt;
      shift_reg_r   <= shift_reg_nxt;
      bit_index_r   <= bit_index_nxt;
      ack_to_send_r <= ack_to_send_nxt;
      ack_seen_r    <= ack_seen_nxt;
      scl_drive_r   <= scl_drive_nxt;
      sda_drive_r   <= sda_drive_nxt;
      rx_hold_r     <= rx_hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2cme_out_stage.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cme_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire i2cme_pkg::result_t up_res,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output i2cme_pkg::result_t      dn_res
);

  logic               valid_r;
  i2cme_pkg::result_t res_r;

  // The register takes a new result when empty or drained this cycle.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Payload register for the pending result.
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= up_res;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2c_master_byte_engine_unit.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine
// Bit-level I2C master sequencer with timed SCL phases and clock stretching.
// ----------------------------------------------------------------------------
// Path: an accepted input item is held in the input register, stepped by the sequencer and kept in the result register.
// Throughput: one item per cycle while the result register has room; the sequencer advances one step per item taken.
// Reset (synchronous, active low) empties both registers, idles the bus
// sequencer with both lines released and loads the default phase lengths.
`default_nettype none

module i2c_master_byte_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [6:0]  in_target_address,
  input  wire logic        in_read_not_write,
  input  wire logic        in_more_follows,
  input  wire logic        in_scl_in,
  input  wire logic        in_sda_in,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_release,
  output logic             out_sda_release,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_received_byte,
  output logic             out_ack_level,
  output logic             out_cmd_rejected,
  // Configuration port
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_wr_data
);

  i2cme_pkg::item_t   in_item;
  i2cme_pkg::item_t   stage_item;
  i2cme_pkg::result_t step_res;
  i2cme_pkg::result_t out_res;
  i2cme_pkg::cfg_t    cfg_r;
  i2cme_pkg::phase_t  seq_phase;
  logic               stage_valid;
  logic               res_ready;
  logic               step;

  // Pack the input fields.
  always_comb begin
    in_item.cmd            = in_cmd;
    in_item.data_byte      = in_data_byte;
    in_item.target_address = in_target_address;
    in_item.read_not_write = in_read_not_write;
    in_item.more_follows   = in_more_follows;
    in_item.scl_in         = in_scl_in;
    in_item.sda_in         = in_sda_in;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_phase_ticks  <= 16'd5;
      cfg_r.high_phase_ticks <= 16'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2cme_pkg::CfgLowIdx:  cfg_r.low_phase_ticks  <= cfg_wr_data;
        i2cme_pkg::CfgHighIdx: cfg_r.high_phase_ticks <= cfg_wr_data;
      endcase
    end
  end

  // The sequencer steps when an item waits and the result register has room.
  assign step = stage_valid && res_ready;

  i2cme_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (stage_valid),
    .dn_take  (step),
    .dn_item  (stage_item)
  );

  i2cme_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (stage_item),
    .cfg   (cfg_r),
    .res   (step_res),
    .phase (seq_phase)
  );

  i2cme_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stage_valid),
    .up_ready (res_ready),
    .up_res   (step_res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_res   (out_res)
  );

  // Unpack the result fields.
  assign out_scl_release   = out_res.scl_release;
  assign out_sda_release   = out_res.sda_release;
  assign out_busy_res      = out_res.busy_res;
  assign out_done_res      = out_res.done_res;
  assign out_received_byte = out_res.received_byte;
  assign out_ack_level     = out_res.ack_level;
  assign out_cmd_rejected  = out_res.cmd_rejected;

  // A completed command always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // A start command taken while idle enters the start wait phase.
  a_start_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && (stage_item.cmd == i2cme_pkg::CmdStart) &&
    (seq_phase == i2cme_pkg::PhIdle) |=> (seq_phase == i2cme_pkg::PhStWait))
    else $error("start command did not enter the wait phase");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

`default_nettype wire
